// ===== rtl/upd_pkg.sv =====
// Shared types, constants and a helper function of the URL percent decoder.
package upd_pkg;

  // Escape character that opens a percent escape
  localparam logic [7:0] PCT_CHAR = 8'h25;

  // Escape phase codes
  localparam logic [1:0] PH_TEXT = 2'd0;  // normal text
  localparam logic [1:0] PH_PCT  = 2'd1;  // '%' seen
  localparam logic [1:0] PH_HELD = 2'd2;  // '%' and one character seen

  // Work entry passed from the front end to the back end
  typedef struct packed {
    logic [2:0][7:0] data;      // result bytes, element 0 goes out first
    logic [1:0]      last_idx;  // index of the final result of this entry
    logic            has_byte;  // 0 for the end-of-string marker
    logic            str_last;  // entry closes the string
  } entry_t;

  // Hex digit check: {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== rtl/upd_front.sv =====
// Front end: accepts input bytes, tracks the escape phase and builds work entries.
module upd_front
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       ready,
  output logic       push,
  output entry_t     entry
);

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [7:0] held;
  logic [7:0] held_next;
  logic [1:0] num;
  logic [4:0] hi_hex;
  logic [4:0] lo_hex;
  logic       accept;

  assign accept = in_valid & ready;
  assign hi_hex = hex_digit(held);
  assign lo_hex = hex_digit(in_byte);

  // Classify the byte against the current phase
  always_comb begin
    phase_next     = phase;
    held_next      = held;
    num            = 2'd0;
    entry.data     = '0;
    entry.has_byte = 1'b1;
    entry.str_last = in_last;
    unique case (phase)
      PH_PCT: begin
        held_next  = in_byte;
        phase_next = PH_HELD;
      end
      PH_HELD: begin
        held_next = 8'd0;
        if (hi_hex[4] && lo_hex[4]) begin
          entry.data[0] = {hi_hex[3:0], lo_hex[3:0]};
          num           = 2'd1;
          phase_next    = PH_TEXT;
        end else begin
          // invalid escape: literal '%', then replay the held char and this one, unless either opens a new escape
          entry.data[0] = PCT_CHAR;
          num           = 2'd1;
          if (held == PCT_CHAR) begin
            held_next  = in_byte;
            phase_next = PH_HELD;
          end else begin
            entry.data[1] = held;
            num           = 2'd2;
            if (in_byte == PCT_CHAR) begin
              phase_next = PH_PCT;
            end else begin
              entry.data[2] = in_byte;
              num           = 2'd3;
              phase_next    = PH_TEXT;
            end
          end
        end
      end
      default: begin
        if (in_byte == PCT_CHAR) begin
          phase_next = PH_PCT;
        end else begin
          entry.data[0] = in_byte;
          num           = 2'd1;
          phase_next    = PH_TEXT;
        end
      end
    endcase
    // end of string drops any pending escape
    if (in_last) begin
      phase_next = PH_TEXT;
      held_next  = 8'd0;
      if (num == 2'd0) begin
        num            = 2'd1;
        entry.has_byte = 1'b0;
      end
    end
    entry.last_idx = num - 2'd1;
  end

  assign push = accept & (num != 2'd0);

  // Escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TEXT;
      held  <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

endmodule

// ===== rtl/upd_queue.sv =====
// Work queue between the front end and the back end.
module upd_queue
  import upd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  output logic   not_full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign not_full   = count != CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/upd_back.sv =====
// Back end: walks the results of each entry and holds them in the output register.
module upd_back
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  entry_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       string_end
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = head_valid & (~out_valid | out_ready);
  assign at_end = idx == head.last_idx;
  assign pop    = load & at_end;

  // Result index within the head entry and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= at_end ? 2'd0 : idx + 2'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= head.data[idx];
      has_byte   <= head.has_byte;
      run_last   <= at_end;
      string_end <= at_end & head.str_last;
    end
  end

endmodule

// ===== rtl/url_percent_decoder.sv =====
// Top level of the URL percent decoder.
// Decodes a percent-encoded string streamed one byte per transfer; s_tlast marks the
// string's last byte. "%hh" becomes one byte, a bad escape gives a literal '%' and the
// following characters, and a pending escape at the end of a string is dropped. The input
// side takes one byte per cycle while the work queue has room; the output side delivers
// one result per cycle while m_tready is high; a byte yields 0 to 3 results, and the
// QUEUE_DEPTH-entry queue absorbs the three-result bursts. A byte's results are written
// to a queue slot and loaded from there into the output register when it is free. A
// last byte that yields nothing gives one marker result with tuser low.
module url_percent_decoder
  import upd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // string_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
  output logic        m_tuser,   // has_byte
  output logic        m_tlast    // string_end
);

  logic       push;
  logic       pop;
  logic       head_valid;
  entry_t     wr_entry;
  entry_t     head;
  logic [7:0] out_byte;
  logic       run_last;

  // Classification and escape state
  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .ready    (s_tready),
    .push     (push),
    .entry    (wr_entry)
  );

  // Work queue
  upd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_entry   (wr_entry),
    .not_full   (s_tready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Result sequencing and output register
  upd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (out_byte),
    .has_byte   (m_tuser),
    .run_last   (run_last),
    .string_end (m_tlast)
  );

  assign m_tdata = {7'd0, run_last, out_byte};

endmodule

// ===== rtl/upd_checker.sv =====
// Port-level checker for the URL percent decoder, bound to the top level.
module upd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output changed");

  // End of string always closes the run
  a_end_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[8])
    else $error("string end without run end");

  // A marker result is only the end of a string and carries a zero byte
  a_marker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && m_tdata[7:0] == 8'd0)
    else $error("bad end marker");

  // No result without a byte and without string end is shown while a non-last input byte is taken
  a_marker_src: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast |-> !(m_tvalid && !m_tuser && !m_tlast))
    else $error("marker outside string end");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);
